// ===== sv/pali_pkg.sv =====
// Shared types and constants of the polyline arc-length interpolator.
package pali_pkg;

	localparam int MaxPointsDef = 256;
	localparam int FracBitsDef  = 16;
	localparam int DataW        = 32;
	localparam int HeadW        = 16;
	localparam int ArcW         = 31;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_FULL = 2'd1,
		STS_FEW  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_SQ, S_RT_INIT, S_RT, S_APPEND, S_SRCH, S_CMP,
		S_RDB, S_CAPB, S_DIV_INIT, S_DIV, S_MUL_INIT, S_MUL, S_RND, S_FINISH
	} state_t;

	typedef enum logic [4:0] {
		DC_NONE, DC_LOAD, DC_CLEAR, DC_SQ_INIT, DC_SQ_STEP, DC_SQRT_INIT,
		DC_SQRT_STEP, DC_APPEND, DC_SRCH_INIT, DC_SRCH_ISSUE, DC_SRCH_CMP,
		DC_RD_A, DC_RD_B, DC_CAP_B, DC_DIV_INIT, DC_DIV_STEP, DC_MUL_INIT,
		DC_MUL_STEP, DC_RND
	} dp_cmd_t;

	typedef struct packed {
		logic signed [DataW-1:0] x;
		logic signed [DataW-1:0] y;
		logic signed [HeadW-1:0] heading;
		logic signed [DataW-1:0] curvature;
		logic signed [DataW-1:0] ref_curvature;
		logic signed [DataW-1:0] accum_dist;
		logic signed [DataW-1:0] lateral;
	} pts_t;

	typedef struct packed {
		dp_cmd_t op;
		logic    res_load;
		logic    res_query;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic few;
		logic srch_done;
		logic iter_done;
	} stat_t;

endpackage

// ===== sv/pali_ctrl.sv =====
// Controller state machine of the polyline arc-length interpolator.
module pali_ctrl import pali_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t  state_q, state_d;
	status_t res_status_q;
	logic    res_query_q;
	logic    out_valid_q;
	logic    can_load;

	assign can_load  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (stat.op) inside
					OP_APPEND: begin
						if (stat.full || stat.empty) state_d = (stat.full) ? S_FINISH : S_APPEND;
						else state_d = S_SQ;
					end
					OP_QUERY: begin
						state_d = stat.few ? S_FINISH : S_SRCH;
					end
					OP_CLEAR, OP_NOP: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_SQ: begin
				if (stat.iter_done) state_d = S_RT_INIT;
			end
			S_RT_INIT: state_d = S_RT;
			S_RT: begin
				if (stat.iter_done) state_d = S_APPEND;
			end
			S_APPEND: state_d = S_FINISH;
			S_SRCH: begin
				state_d = stat.srch_done ? S_RDB : S_CMP;
			end
			S_CMP: state_d = S_SRCH;
			S_RDB: state_d = S_CAPB;
			S_CAPB: state_d = S_DIV_INIT;
			S_DIV_INIT: state_d = S_DIV;
			S_DIV: begin
				if (stat.iter_done) state_d = S_MUL_INIT;
			end
			S_MUL_INIT: state_d = S_MUL;
			S_MUL: begin
				if (stat.iter_done) state_d = S_RND;
			end
			S_RND: state_d = S_FINISH;
			S_FINISH: begin
				if (can_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op         = DC_NONE;
		cmd.res_load   = 1'b0;
		cmd.res_query  = res_query_q;
		cmd.res_status = res_status_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) cmd.op = DC_LOAD;
			end
			S_DECODE: begin
				unique case (stat.op) inside
					OP_APPEND: begin
						// The first point is stored from the append state.
						if (!stat.full && !stat.empty) cmd.op = DC_SQ_INIT;
					end
					OP_QUERY: begin
						if (!stat.few) cmd.op = DC_SRCH_INIT;
					end
					OP_CLEAR: cmd.op = DC_CLEAR;
					OP_NOP: cmd.op = DC_NONE;
				endcase
			end
			S_SQ:       cmd.op = DC_SQ_STEP;
			S_RT_INIT:  cmd.op = DC_SQRT_INIT;
			S_RT:       cmd.op = DC_SQRT_STEP;
			S_APPEND:   cmd.op = DC_APPEND;
			S_SRCH:     cmd.op = stat.srch_done ? DC_RD_A : DC_SRCH_ISSUE;
			S_CMP:      cmd.op = DC_SRCH_CMP;
			S_RDB:      cmd.op = DC_RD_B;
			S_CAPB:     cmd.op = DC_CAP_B;
			S_DIV_INIT: cmd.op = DC_DIV_INIT;
			S_DIV:      cmd.op = DC_DIV_STEP;
			S_MUL_INIT: cmd.op = DC_MUL_INIT;
			S_MUL:      cmd.op = DC_MUL_STEP;
			S_RND:      cmd.op = DC_RND;
			S_FINISH:   cmd.res_load = can_load;
			default:    cmd.op = DC_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			res_status_q <= STS_OK;
			res_query_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (state_q == S_DECODE) begin
				res_query_q  <= (stat.op == OP_QUERY) && !stat.few;
				if ((stat.op == OP_APPEND) && stat.full) res_status_q <= STS_FULL;
				else if ((stat.op == OP_QUERY) && stat.few) res_status_q <= STS_FEW;
				else res_status_q <= STS_OK;
			end
		end
	end

endmodule

// ===== sv/pali_datapath.sv =====
// Datapath: point memories, segment length, search, divider and interpolation lanes.
module pali_datapath import pali_pkg::*; #(
	parameter int MAX_POINTS       = MaxPointsDef,
	parameter int FACTOR_FRAC_BITS = FracBitsDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	input  logic [1:0]              op,
	input  logic signed [DataW-1:0] point_x,
	input  logic signed [DataW-1:0] point_y,
	input  logic signed [HeadW-1:0] point_heading,
	input  logic signed [DataW-1:0] point_curvature,
	input  logic signed [DataW-1:0] point_ref_curvature,
	input  logic signed [DataW-1:0] point_accum_dist,
	input  logic signed [DataW-1:0] point_lateral,
	input  logic signed [DataW-1:0] query_len,
	output logic [1:0]              status,
	output logic signed [DataW-1:0] out_x,
	output logic signed [DataW-1:0] out_y,
	output logic signed [HeadW-1:0] out_heading,
	output logic signed [DataW-1:0] out_curvature,
	output logic signed [DataW-1:0] out_ref_curvature,
	output logic signed [DataW-1:0] out_accum_dist,
	output logic signed [DataW-1:0] out_lateral
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int FB    = FACTOR_FRAC_BITS;
	localparam int QW    = 33 + FB;
	localparam int PW    = DataW + QW;
	localparam int HPW   = HeadW + 1 + QW;
	localparam int TW    = PW + 1 - FB;
	localparam int ITW   = $clog2(QW);
	localparam int SQW   = 66;
	localparam int RTW   = 33;
	localparam int LANES = 6;
	localparam logic [ArcW-1:0]      ArcMax = {ArcW{1'b1}};
	localparam logic [PW:0]          LHalf  = (PW+1)'(1) << (FB - 1);
	localparam logic [HPW:0]         HHalf  = (HPW+1)'(1) << (FB - 1);
	localparam logic [TW-1:0]        TBig   = TW'(64'h100_0000_0000);
	localparam logic signed [42:0]   RMax   = 43'sd2147483647;
	localparam logic signed [42:0]   RMin   = -43'sd2147483648;

	// Captured word and table state.
	op_t                    op_q;
	pts_t                   pin_q;
	logic signed [DataW-1:0] qlen_q;
	logic [CW-1:0]          count_q;
	logic signed [DataW-1:0] prev_x_q, prev_y_q;
	logic [ArcW-1:0]        prev_arc_q;
	logic [ITW-1:0]         cnt_q;

	// Memories.
	pts_t            pts_mem [MAX_POINTS];
	logic [ArcW-1:0] arc_mem [MAX_POINTS];
	pts_t            pts_rd_q;
	logic [ArcW-1:0] arc_rd_q;
	logic [AW-1:0]   rd_addr;

	// Segment length.
	logic signed [32:0] dx, dy;
	logic [31:0]        dxm, dym, mx_q, my_q;
	logic [SQW-1:0]     sq_q;
	logic [33:0]        rem_q;
	logic [RTW-1:0]     root_q;
	logic [35:0]        rt_rem2, rt_trial, rt_diff;
	logic               rt_ge;
	logic [33:0]        seg_len;
	logic [34:0]        arc_sum;
	logic [ArcW-1:0]    arc_new;

	// Search.
	logic [CW-1:0] lo_q, hi_q;
	logic [CW:0]   mid_sum;
	logic [AW-1:0] mid_w, mid_q, idx_w, idx_q;
	logic          arc_lt;

	// Factor and lanes.
	logic [ArcW-1:0]    arc_a_q, arc_b_q, seg_q, segw, drem_q;
	pts_t               pa_q, pb_q;
	logic signed [32:0] qdist;
	logic [31:0]        dmag;
	logic [QW-1:0]      num_q;
	logic [31:0]        dv_r2, dv_diff;
	logic               dv_bit;
	logic signed [DataW-1:0] la_w [LANES];
	logic signed [DataW-1:0] lb_w [LANES];
	logic signed [32:0]      ld_w [LANES];
	logic [31:0]        lm_q [LANES];
	logic               ln_q [LANES];
	logic [PW-1:0]      lacc_q [LANES];
	logic [PW:0]        lsum_w [LANES];
	logic [TW-1:0]      lt_w [LANES];
	logic [40:0]        lt_q [LANES];
	logic               lbig_q [LANES];
	logic signed [42:0] lr_w [LANES];
	logic signed [DataW-1:0] lres_w [LANES];
	logic [HeadW-1:0]   hd;
	logic [HeadW:0]     hdx, hm_q;
	logic               hn_q;
	logic [HPW-1:0]     hacc_q;
	logic [HPW:0]       hsum;
	logic [HeadW-1:0]   ht_q, hres;

	// Output registers.
	status_t                 status_q;
	logic signed [DataW-1:0] ox_q, oy_q, oc_q, orc_q, oad_q, olat_q;
	logic signed [HeadW-1:0] oh_q;

	assign stat.op        = op_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CW'(MAX_POINTS));
	assign stat.few       = (count_q < CW'(2));
	assign stat.srch_done = (lo_q >= hi_q);
	assign stat.iter_done = (cnt_q == '0);

	// Squared length, one bit of each magnitude per cycle, MSB first.
	assign dx  = {pin_q.x[31], pin_q.x} - {prev_x_q[31], prev_x_q};
	assign dy  = {pin_q.y[31], pin_q.y} - {prev_y_q[31], prev_y_q};
	assign dxm = dx[32] ? 32'(-dx) : dx[31:0];
	assign dym = dy[32] ? 32'(-dy) : dy[31:0];

	// Digit-by-digit square root: two operand bits in, one root bit out.
	assign rt_rem2  = {rem_q, sq_q[SQW-1 -: 2]};
	assign rt_trial = {1'b0, root_q, 2'b01};
	assign rt_ge    = (rt_rem2 >= rt_trial);
	assign rt_diff  = rt_rem2 - rt_trial;
	assign seg_len  = {1'b0, root_q} + 34'(rem_q > {1'b0, root_q});
	assign arc_sum  = {4'b0, prev_arc_q} + {1'b0, seg_len};
	assign arc_new  = (count_q == '0) ? '0 :
	                  (arc_sum > 35'(ArcMax)) ? ArcMax : arc_sum[ArcW-1:0];

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = mid_sum[AW:1];
	assign arc_lt  = ($signed({1'b0, arc_rd_q}) < qlen_q);
	assign idx_w   = (lo_q == '0) ? '0 :
	                 (lo_q == count_q) ? AW'(count_q - CW'(2)) : AW'(lo_q - CW'(1));

	always_comb begin
		case (cmd.op)
			DC_SRCH_ISSUE: rd_addr = mid_w;
			DC_RD_A:       rd_addr = idx_w;
			default:       rd_addr = AW'(idx_q + 1'b1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DC_APPEND) begin
			pts_mem[count_q[AW-1:0]] <= pin_q;
			arc_mem[count_q[AW-1:0]] <= arc_new;
		end
		pts_rd_q <= pts_mem[rd_addr];
		arc_rd_q <= arc_mem[rd_addr];
	end

	// Factor numerator and divider.
	assign qdist   = {qlen_q[31], qlen_q} - {2'b0, arc_a_q};
	assign dmag    = qdist[32] ? 32'(-qdist) : qdist[31:0];
	assign segw    = arc_b_q - arc_a_q;
	assign dv_r2   = {drem_q, num_q[QW-1]};
	assign dv_bit  = (seg_q != '0) && (dv_r2 >= {1'b0, seg_q});
	assign dv_diff = dv_r2 - {1'b0, seg_q};

	assign la_w = '{pa_q.x, pa_q.y, pa_q.curvature, pa_q.ref_curvature,
	                pa_q.accum_dist, pa_q.lateral};
	assign lb_w = '{pb_q.x, pb_q.y, pb_q.curvature, pb_q.ref_curvature,
	                pb_q.accum_dist, pb_q.lateral};
	assign hd   = pb_q.heading - pa_q.heading;
	assign hdx  = {hd[HeadW-1], hd};
	assign hsum = {1'b0, hacc_q} + HHalf;
	assign hres = hn_q ? (pa_q.heading - ht_q) : (pa_q.heading + ht_q);

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			ld_w[k]   = {lb_w[k][31], lb_w[k]} - {la_w[k][31], la_w[k]};
			lsum_w[k] = {1'b0, lacc_q[k]} + LHalf;
			lt_w[k]   = lsum_w[k][PW:FB];
			lr_w[k]   = ln_q[k] ? ({{11{la_w[k][31]}}, la_w[k]} - {2'b0, lt_q[k]}) :
			                      ({{11{la_w[k][31]}}, la_w[k]} + {2'b0, lt_q[k]});
			if (lbig_q[k]) lres_w[k] = ln_q[k] ? DataW'(RMin) : DataW'(RMax);
			else if (lr_w[k] > RMax) lres_w[k] = DataW'(RMax);
			else if (lr_w[k] < RMin) lres_w[k] = DataW'(RMin);
			else lres_w[k] = lr_w[k][DataW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == DC_CLEAR) begin
			count_q <= '0;
		end else if (cmd.op == DC_APPEND) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DC_LOAD: begin
				op_q   <= op_t'(op);
				pin_q  <= {point_x, point_y, point_heading, point_curvature,
				           point_ref_curvature, point_accum_dist, point_lateral};
				qlen_q <= query_len;
			end
			DC_SQ_INIT: begin
				mx_q  <= dxm;
				my_q  <= dym;
				sq_q  <= '0;
				cnt_q <= ITW'(31);
			end
			DC_SQ_STEP: begin
				sq_q  <= (sq_q << 1) + (mx_q[31] ? SQW'(dxm) : '0) +
				         (my_q[31] ? SQW'(dym) : '0);
				mx_q  <= mx_q << 1;
				my_q  <= my_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			DC_SQRT_INIT: begin
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= ITW'(RTW - 1);
			end
			DC_SQRT_STEP: begin
				rem_q  <= rt_ge ? rt_diff[33:0] : rt_rem2[33:0];
				root_q <= {root_q[RTW-2:0], rt_ge};
				sq_q   <= sq_q << 2;
				cnt_q  <= cnt_q - 1'b1;
			end
			DC_APPEND: begin
				prev_x_q   <= pin_q.x;
				prev_y_q   <= pin_q.y;
				prev_arc_q <= arc_new;
			end
			DC_SRCH_INIT: begin
				lo_q <= '0;
				hi_q <= count_q;
			end
			DC_SRCH_ISSUE: mid_q <= mid_w;
			DC_SRCH_CMP: begin
				if (arc_lt) lo_q <= CW'(mid_q) + 1'b1;
				else hi_q <= CW'(mid_q);
			end
			DC_RD_A: idx_q <= idx_w;
			DC_RD_B: begin
				arc_a_q <= arc_rd_q;
				pa_q    <= pts_rd_q;
			end
			DC_CAP_B: begin
				arc_b_q <= arc_rd_q;
				pb_q    <= pts_rd_q;
			end
			DC_DIV_INIT: begin
				num_q  <= QW'({dmag, {FB{1'b0}}}) + QW'(segw[ArcW-1:1]);
				seg_q  <= segw;
				drem_q <= '0;
				cnt_q  <= ITW'(QW - 1);
				for (int k = 0; k < LANES; k++) begin
					lm_q[k] <= ld_w[k][32] ? 32'(-ld_w[k]) : ld_w[k][31:0];
					ln_q[k] <= ld_w[k][32] ^ qdist[32];
				end
				hm_q <= hd[HeadW-1] ? (HeadW+1)'(-hdx) : hdx;
				hn_q <= hd[HeadW-1] ^ qdist[32];
			end
			DC_DIV_STEP: begin
				drem_q <= dv_bit ? dv_diff[ArcW-1:0] : dv_r2[ArcW-1:0];
				num_q  <= {num_q[QW-2:0], dv_bit};
				cnt_q  <= cnt_q - 1'b1;
			end
			DC_MUL_INIT: begin
				for (int k = 0; k < LANES; k++) lacc_q[k] <= '0;
				hacc_q <= '0;
				cnt_q  <= ITW'(QW - 1);
			end
			DC_MUL_STEP: begin
				for (int k = 0; k < LANES; k++) begin
					lacc_q[k] <= (lacc_q[k] << 1) + (num_q[QW-1] ? PW'(lm_q[k]) : '0);
				end
				hacc_q <= (hacc_q << 1) + (num_q[QW-1] ? HPW'(hm_q) : '0);
				num_q  <= num_q << 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			DC_RND: begin
				for (int k = 0; k < LANES; k++) begin
					lt_q[k]   <= lt_w[k][40:0];
					lbig_q[k] <= (lt_w[k] > TBig);
				end
				ht_q <= hsum[FB+HeadW-1:FB];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			ox_q     <= cmd.res_query ? lres_w[0] : '0;
			oy_q     <= cmd.res_query ? lres_w[1] : '0;
			oh_q     <= cmd.res_query ? hres : '0;
			oc_q     <= cmd.res_query ? lres_w[2] : '0;
			orc_q    <= cmd.res_query ? lres_w[3] : '0;
			oad_q    <= cmd.res_query ? lres_w[4] : '0;
			olat_q   <= cmd.res_query ? lres_w[5] : '0;
		end
	end

	assign status            = status_q;
	assign out_x             = ox_q;
	assign out_y             = oy_q;
	assign out_heading       = oh_q;
	assign out_curvature     = oc_q;
	assign out_ref_curvature = orc_q;
	assign out_accum_dist    = oad_q;
	assign out_lateral       = olat_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count exceeds table depth");

	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DC_SRCH_ISSUE |-> lo_q < hi_q)
		else $error("search probe issued on an empty interval");

	a_append_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DC_APPEND |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not advance the point count");

endmodule

// ===== sv/polyline_arc_length_interpolator.sv =====
// Appends after the first point run 32 squaring steps, then 33 root steps to find the segment
// length. A query runs a binary search, issuing then comparing each probe, then a one-bit
// divider and a one-bit multiply over 33+FACTOR_FRAC_BITS factor bits.
// One word is worked on at a time; a new word is taken while the last result waits.
// Asynchronous active-low reset empties the table; point memories are not cleared.
module polyline_arc_length_interpolator import pali_pkg::*; #(
	parameter int MAX_POINTS       = MaxPointsDef,
	parameter int FACTOR_FRAC_BITS = FracBitsDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              op,
	input  logic signed [DataW-1:0] point_x,
	input  logic signed [DataW-1:0] point_y,
	input  logic signed [HeadW-1:0] point_heading,
	input  logic signed [DataW-1:0] point_curvature,
	input  logic signed [DataW-1:0] point_ref_curvature,
	input  logic signed [DataW-1:0] point_accum_dist,
	input  logic signed [DataW-1:0] point_lateral,
	input  logic signed [DataW-1:0] query_len,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [DataW-1:0] out_x,
	output logic signed [DataW-1:0] out_y,
	output logic signed [HeadW-1:0] out_heading,
	output logic signed [DataW-1:0] out_curvature,
	output logic signed [DataW-1:0] out_ref_curvature,
	output logic signed [DataW-1:0] out_accum_dist,
	output logic signed [DataW-1:0] out_lateral
);

	cmd_t  cmd;
	stat_t stat;

	pali_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pali_datapath #(
		.MAX_POINTS       (MAX_POINTS),
		.FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.op                  (op),
		.point_x             (point_x),
		.point_y             (point_y),
		.point_heading       (point_heading),
		.point_curvature     (point_curvature),
		.point_ref_curvature (point_ref_curvature),
		.point_accum_dist    (point_accum_dist),
		.point_lateral       (point_lateral),
		.query_len           (query_len),
		.status              (status),
		.out_x               (out_x),
		.out_y               (out_y),
		.out_heading         (out_heading),
		.out_curvature       (out_curvature),
		.out_ref_curvature   (out_ref_curvature),
		.out_accum_dist      (out_accum_dist),
		.out_lateral         (out_lateral)
	);

endmodule
